[hdl/okvt_pkg.sv]
// Shared request/status codes and controller-datapath interface types.
`default_nettype none
package okvt_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_SEARCH = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_DUPLICATE = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;

    typedef struct packed {
        logic       load_req;
        logic       scan_start;
        logic       scan_run;
        logic       shift_start;
        logic       shift_run;
        logic       wr_insert;
        logic       wr_update;
        logic       cnt_dec;
        logic       load_out;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic       match;
        logic       busy;
        logic       hit;
        logic       full;
        logic       out_free;
        logic [1:0] req;
    } t_dp_sts;

endpackage
`default_nettype wire

[hdl/okvt_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module okvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/okvt_dp.sv]
// Datapath: key/value memories, scan and shift pipeline, count and result register.
`default_nettype none
module okvt_dp #(
    parameter int DEPTH = 64
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire okvt_pkg::t_dp_cmd          i_cmd,
    output okvt_pkg::t_dp_sts               o_sts,
    input  wire [1:0]                       i_req,
    input  wire [okvt_pkg::KEY_W-1:0]       i_key,
    input  wire [okvt_pkg::VALUE_W-1:0]     i_value,
    input  wire                             i_out_ready,
    output logic                            o_out_valid,
    output logic [1:0]                      o_out_status,
    output logic [okvt_pkg::POS_W-1:0]      o_out_pos,
    output logic [okvt_pkg::CNT_W-1:0]      o_out_cnt
);
    import okvt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [1:0]         r_req;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_val;
    logic [CW-1:0]      r_rd_idx;
    logic               r_cmp_valid;
    logic [AW-1:0]      r_cmp_idx;
    logic               r_hit;
    logic [AW-1:0]      r_pos;
    logic [CW-1:0]      r_count;

    logic [KEY_W-1:0]   key_rdata;
    logic [VALUE_W-1:0] val_rdata;
    logic               issue_ok;
    logic               issue;
    logic               match;
    logic               shift_wr;
    logic               key_we;
    logic               val_we;
    logic [AW-1:0]      waddr;
    logic [KEY_W-1:0]   key_wdata;
    logic [VALUE_W-1:0] val_wdata;

    assign issue_ok  = r_rd_idx < r_count;
    assign issue     = (i_cmd.scan_run || i_cmd.shift_run) && issue_ok;
    assign match     = i_cmd.scan_run && r_cmp_valid && (key_rdata == r_key);
    assign shift_wr  = i_cmd.shift_run && r_cmp_valid;
    assign key_we    = i_cmd.wr_insert || shift_wr;
    assign val_we    = i_cmd.wr_insert || i_cmd.wr_update || shift_wr;
    assign key_wdata = i_cmd.wr_insert ? r_key : key_rdata;
    assign val_wdata = shift_wr ? val_rdata : r_val;

    always_comb begin
        priority if (i_cmd.wr_insert) begin
            waddr = r_count[AW-1:0];
        end else if (i_cmd.wr_update) begin
            waddr = r_pos;
        end else begin
            waddr = r_cmp_idx - AW'(1);
        end
    end

    okvt_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (key_rdata)
    );

    okvt_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (val_rdata)
    );

    // request, scan payload and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
            r_key <= i_key;
            r_val <= i_value;
        end
        if (i_cmd.scan_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.shift_start) begin
            r_rd_idx <= CW'(r_pos) + CW'(1);
        end else if (issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        if (issue) begin
            r_cmp_idx <= r_rd_idx[AW-1:0];
        end
        if (i_cmd.scan_start) begin
            r_hit <= 1'b0;
        end else if (match) begin
            r_hit <= 1'b1;
        end
        if (match) begin
            r_pos <= r_cmp_idx;
        end else if (i_cmd.wr_insert) begin
            r_pos <= r_count[AW-1:0];
        end
        if (i_cmd.load_out) begin
            o_out_status <= i_cmd.status;
            o_out_pos    <= (i_cmd.status == STS_OK) ? POS_W'(r_pos) : '0;
            o_out_cnt    <= CNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_start || i_cmd.shift_start) begin
                r_cmp_valid <= 1'b0;
            end else begin
                r_cmp_valid <= issue;
            end
            if (i_cmd.wr_insert) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.match    = match;
    assign o_sts.busy     = issue_ok || r_cmp_valid;
    assign o_sts.hit      = r_hit;
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.out_free = !o_out_valid || i_out_ready;
    assign o_sts.req      = r_req;
endmodule
`default_nettype wire

[hdl/okvt_ctrl.sv]
// Controller: sequences scan, table update, remove compaction and result hand-off.
`default_nettype none
module okvt_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire okvt_pkg::t_dp_sts i_sts,
    output okvt_pkg::t_dp_cmd      o_cmd
);
    import okvt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_ACT   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_status;
    logic [1:0] n_status;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.match || !i_sts.busy) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_DONE;
                unique case (i_sts.req)
                    REQ_INSERT: begin
                        priority if (i_sts.hit) begin
                            n_status = STS_DUPLICATE;
                        end else if (i_sts.full) begin
                            n_status = STS_FULL;
                        end else begin
                            n_status        = STS_OK;
                            o_cmd.wr_insert = 1'b1;
                        end
                    end
                    REQ_REMOVE: begin
                        if (i_sts.hit) begin
                            n_status          = STS_OK;
                            o_cmd.shift_start = 1'b1;
                            n_state           = S_SHIFT;
                        end else begin
                            n_status = STS_NOT_FOUND;
                        end
                    end
                    REQ_UPDATE: begin
                        if (i_sts.hit) begin
                            n_status        = STS_OK;
                            o_cmd.wr_update = 1'b1;
                        end else begin
                            n_status = STS_NOT_FOUND;
                        end
                    end
                    REQ_SEARCH: begin
                        n_status = i_sts.hit ? STS_OK : STS_NOT_FOUND;
                    end
                endcase
            end
            S_SHIFT: begin
                o_cmd.shift_run = 1'b1;
                if (!i_sts.busy) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= STS_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end
endmodule
`default_nettype wire

[hdl/ordered_key_value_table_unit.sv]
// Top level of the ordered key/value table.
// Holds up to DEPTH entries (64-bit key, signed 32-bit value) in insertion order.
// One request word in, one result word out. A request first scans the key memory,
// one entry per cycle through its single read port, stopping at the first match.
// A remove that hits then compacts the entries above the hit, one per cycle.
// After the result is loaded the controller returns to idle before it takes the
// next request. The next request word is taken while the previous result still
// waits on the output.
`default_nettype none
module ordered_key_value_table_unit #(
    parameter int DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [95:0]  s_tdata,   // key[63:0], new_value[95:64]
    input  wire [1:0]   s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // position[5:0], entry_count[12:6], zero[15:13]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import okvt_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [POS_W-1:0] out_pos;
    logic [CNT_W-1:0] out_cnt;

    okvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    okvt_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req        (s_tuser),
        .i_key        (s_tdata[KEY_W-1:0]),
        .i_value      (s_tdata[KEY_W+VALUE_W-1:KEY_W]),
        .i_out_ready  (m_tready),
        .o_out_valid  (m_tvalid),
        .o_out_status (m_tuser),
        .o_out_pos    (out_pos),
        .o_out_cnt    (out_cnt)
    );

    assign m_tdata = {3'b000, out_cnt, out_pos};
endmodule
`default_nettype wire
